// ===== rtl/ciir_pkg.sv =====
// shared types and constants of the complex iir filter
package ciir_pkg;

	// default sizes
	localparam int DEF_MAX_NUM_TAPS = 16;
	localparam int DEF_MAX_DEN_TAPS = 16;
	localparam int DEF_COEF_WIDTH   = 24;

	// fixed field widths
	localparam int OPCODE_W = 2;
	localparam int SAMPLE_W = 16;
	localparam int INDEX_W  = 4;
	localparam int COUNT_W  = 5;

	// feedback word: 40 bits, 16 fraction bits
	localparam int Y_W    = 40;
	localparam int Y_FRAC = 16;
	// accumulator: 20 fraction bits
	localparam int ACC_W     = 64;
	localparam int ACC_EXTRA = 4;
	// data operand of the shared multipliers
	localparam int DATA_W = Y_W - Y_FRAC + 1;

	// configuration register indexes
	localparam logic REG_NUM_COUNT = 1'b0;
	localparam logic REG_DEN_COUNT = 1'b1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_SAMPLE   = 2'd0,
		OP_LOAD_NUM = 2'd1,
		OP_LOAD_DEN = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

endpackage

// ===== rtl/complex_iir_filter.sv =====
// complex direct-form-I iir filter with one shared complex multiply-accumulate unit
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   opcode, sample_re/im, coef_index, coef_re/im
//  out      output     out_valid / out_ready out_re, out_im, clipped
//  cfg      input      cfg_we                cfg_index, cfg_data
//
// the single complex multiplier bank does one feedforward tap per cycle and one
// feedback tap in a high-half and a low-half pass of the stored y
// loads and clears finish in the cycle of their transfer
// reset clears counts to one, all coefficient tables and both histories
// a finished result sits in the output register; a later sample stalls only in its
// last cycle if that register is still full

module complex_iir_filter #(
	parameter int MAX_NUM_TAPS = ciir_pkg::DEF_MAX_NUM_TAPS,
	parameter int MAX_DEN_TAPS = ciir_pkg::DEF_MAX_DEN_TAPS,
	parameter int COEF_WIDTH   = ciir_pkg::DEF_COEF_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [ciir_pkg::COUNT_W-1:0]         cfg_data,

	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [ciir_pkg::OPCODE_W-1:0]        opcode,
	input  logic signed [ciir_pkg::SAMPLE_W-1:0] sample_re,
	input  logic signed [ciir_pkg::SAMPLE_W-1:0] sample_im,
	input  logic [ciir_pkg::INDEX_W-1:0]         coef_index,
	input  logic signed [COEF_WIDTH-1:0]         coef_re,
	input  logic signed [COEF_WIDTH-1:0]         coef_im,

	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [ciir_pkg::SAMPLE_W-1:0] out_re,
	output logic signed [ciir_pkg::SAMPLE_W-1:0] out_im,
	output logic                                 clipped
);

	localparam int TAPS_MAX = (MAX_NUM_TAPS > MAX_DEN_TAPS) ? MAX_NUM_TAPS : MAX_DEN_TAPS;
	localparam int KW       = $clog2(TAPS_MAX + 1);
	localparam int NUM_IW   = (MAX_NUM_TAPS > 1) ? $clog2(MAX_NUM_TAPS) : 1;
	localparam int DEN_IW   = (MAX_DEN_TAPS > 1) ? $clog2(MAX_DEN_TAPS) : 1;
	localparam int PW       = COEF_WIDTH + ciir_pkg::DATA_W;
	localparam int Y_W      = ciir_pkg::Y_W;
	localparam int ACC_W    = ciir_pkg::ACC_W;
	localparam int SW       = ciir_pkg::SAMPLE_W;
	localparam int HI_W     = Y_W - ciir_pkg::Y_FRAC;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NUM,
		ST_DEN_HI,
		ST_DEN_LO,
		ST_DRAIN,
		ST_YCALC,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic [KW-1:0] k_q;

	// configuration
	logic [ciir_pkg::COUNT_W-1:0] num_count_q, den_count_q;

	// coefficient tables and histories
	logic signed [COEF_WIDTH-1:0] num_re_q [MAX_NUM_TAPS];
	logic signed [COEF_WIDTH-1:0] num_im_q [MAX_NUM_TAPS];
	logic signed [COEF_WIDTH-1:0] den_re_q [MAX_DEN_TAPS];
	logic signed [COEF_WIDTH-1:0] den_im_q [MAX_DEN_TAPS];
	logic signed [SW-1:0]         xh_re_q  [MAX_NUM_TAPS];
	logic signed [SW-1:0]         xh_im_q  [MAX_NUM_TAPS];
	logic signed [Y_W-1:0]        yh_re_q  [MAX_DEN_TAPS];
	logic signed [Y_W-1:0]        yh_im_q  [MAX_DEN_TAPS];

	// multiplier products and their tags
	logic signed [PW-1:0] prod_rr_q, prod_ii_q, prod_ri_q, prod_ir_q;
	logic                 pv_q, pshift_q, psub_q;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic signed [Y_W-1:0]   y_re_q, y_im_q;

	// output register
	logic                 out_valid_q, clipped_q;
	logic signed [SW-1:0] out_re_q, out_im_q;

	ciir_pkg::op_t op;
	logic          in_xfer, start, out_free;
	assign op       = ciir_pkg::op_t'(opcode);
	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign start    = in_xfer && (op == ciir_pkg::OP_SAMPLE);
	assign out_free = !out_valid_q || out_ready;

	// last tap index for feedforward, number of feedback taps
	logic [KW-1:0] nb_last, na_last;
	always_comb begin
		if (num_count_q == '0) begin
			nb_last = '0;
		end else if (32'(num_count_q) > MAX_NUM_TAPS) begin
			nb_last = KW'(MAX_NUM_TAPS - 1);
		end else begin
			nb_last = KW'(num_count_q - 1'b1);
		end
		if (den_count_q == '0) begin
			na_last = '0;
		end else if (32'(den_count_q) > MAX_DEN_TAPS) begin
			na_last = KW'(MAX_DEN_TAPS - 1);
		end else begin
			na_last = KW'(den_count_q - 1'b1);
		end
	end

	// operand select for the shared complex multiplier
	logic [NUM_IW-1:0]            num_idx;
	logic [DEN_IW-1:0]            den_idx, yh_idx;
	logic signed [COEF_WIDTH-1:0] c_re, c_im;
	logic signed [ciir_pkg::DATA_W-1:0] d_re, d_im;
	logic signed [Y_W-1:0]        y_sel_re, y_sel_im;
	logic                         issue;

	assign num_idx  = NUM_IW'(k_q);
	assign yh_idx   = DEN_IW'(k_q);
	assign den_idx  = DEN_IW'(k_q + 1'b1);
	assign y_sel_re = yh_re_q[yh_idx];
	assign y_sel_im = yh_im_q[yh_idx];
	assign issue    = (state_q == ST_NUM) || (state_q == ST_DEN_HI) || (state_q == ST_DEN_LO);

	always_comb begin
		unique case (state_q)
			ST_NUM: begin
				c_re = num_re_q[num_idx];
				c_im = num_im_q[num_idx];
				d_re = ciir_pkg::DATA_W'(xh_re_q[num_idx]);
				d_im = ciir_pkg::DATA_W'(xh_im_q[num_idx]);
			end
			ST_DEN_HI: begin
				// integer part of y, signed
				c_re = den_re_q[den_idx];
				c_im = den_im_q[den_idx];
				d_re = ciir_pkg::DATA_W'($signed(y_sel_re[Y_W-1:ciir_pkg::Y_FRAC]));
				d_im = ciir_pkg::DATA_W'($signed(y_sel_im[Y_W-1:ciir_pkg::Y_FRAC]));
			end
			ST_DEN_LO: begin
				// fraction part of y, unsigned
				c_re = den_re_q[den_idx];
				c_im = den_im_q[den_idx];
				d_re = $signed({{(ciir_pkg::DATA_W-ciir_pkg::Y_FRAC){1'b0}},
					y_sel_re[ciir_pkg::Y_FRAC-1:0]});
				d_im = $signed({{(ciir_pkg::DATA_W-ciir_pkg::Y_FRAC){1'b0}},
					y_sel_im[ciir_pkg::Y_FRAC-1:0]});
			end
			default: begin
				c_re = '0;
				c_im = '0;
				d_re = '0;
				d_im = '0;
			end
		endcase
	end

	// product terms, each floored by 2^16 in the low-half pass
	logic signed [ACC_W-1:0] t_rr, t_ii, t_ri, t_ir, t_re, t_im;
	always_comb begin
		if (pshift_q) begin
			t_rr = ACC_W'(prod_rr_q >>> ciir_pkg::Y_FRAC);
			t_ii = ACC_W'(prod_ii_q >>> ciir_pkg::Y_FRAC);
			t_ri = ACC_W'(prod_ri_q >>> ciir_pkg::Y_FRAC);
			t_ir = ACC_W'(prod_ir_q >>> ciir_pkg::Y_FRAC);
		end else begin
			t_rr = ACC_W'(prod_rr_q);
			t_ii = ACC_W'(prod_ii_q);
			t_ri = ACC_W'(prod_ri_q);
			t_ir = ACC_W'(prod_ir_q);
		end
		t_re = t_rr - t_ii;
		t_im = t_ri + t_ir;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			prod_rr_q <= c_re * d_re;
			prod_ii_q <= c_im * d_im;
			prod_ri_q <= c_re * d_im;
			prod_ir_q <= c_im * d_re;
		end
		if (start) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (pv_q) begin
			if (psub_q) begin
				acc_re_q <= acc_re_q - t_re;
				acc_im_q <= acc_im_q - t_im;
			end else begin
				acc_re_q <= acc_re_q + t_re;
				acc_im_q <= acc_im_q + t_im;
			end
		end
	end

	// accumulator to stored y: truncate toward zero by 2^4, saturate to 40 bits
	logic signed [ACC_W-1:0] acc_adj_re, acc_adj_im, acc_q_re, acc_q_im;
	logic signed [Y_W-1:0]   y_new_re, y_new_im;
	logic [ACC_W-Y_W:0]      top_re, top_im;
	always_comb begin
		acc_adj_re = acc_re_q + (acc_re_q[ACC_W-1] ? ACC_W'(15) : ACC_W'(0));
		acc_adj_im = acc_im_q + (acc_im_q[ACC_W-1] ? ACC_W'(15) : ACC_W'(0));
		acc_q_re   = acc_adj_re >>> ciir_pkg::ACC_EXTRA;
		acc_q_im   = acc_adj_im >>> ciir_pkg::ACC_EXTRA;
		top_re     = acc_q_re[ACC_W-1:Y_W-1];
		top_im     = acc_q_im[ACC_W-1:Y_W-1];
		if (&top_re || ~|top_re) begin
			y_new_re = acc_q_re[Y_W-1:0];
		end else begin
			y_new_re = {acc_q_re[ACC_W-1], {(Y_W-1){~acc_q_re[ACC_W-1]}}};
		end
		if (&top_im || ~|top_im) begin
			y_new_im = acc_q_im[Y_W-1:0];
		end else begin
			y_new_im = {acc_q_im[ACC_W-1], {(Y_W-1){~acc_q_im[ACC_W-1]}}};
		end
	end

	// stored y to int16: truncate toward zero, saturate, flag
	logic signed [Y_W-1:0]  y_adj_re, y_adj_im;
	logic signed [HI_W-1:0] o_full_re, o_full_im;
	logic [HI_W-SW:0]       otop_re, otop_im;
	logic signed [SW-1:0]   o_re, o_im;
	logic                   clip_re, clip_im;
	always_comb begin
		y_adj_re  = y_re_q + (y_re_q[Y_W-1] ? Y_W'(65535) : Y_W'(0));
		y_adj_im  = y_im_q + (y_im_q[Y_W-1] ? Y_W'(65535) : Y_W'(0));
		o_full_re = y_adj_re[Y_W-1:ciir_pkg::Y_FRAC];
		o_full_im = y_adj_im[Y_W-1:ciir_pkg::Y_FRAC];
		otop_re   = o_full_re[HI_W-1:SW-1];
		otop_im   = o_full_im[HI_W-1:SW-1];
		clip_re   = !(&otop_re || ~|otop_re);
		clip_im   = !(&otop_im || ~|otop_im);
		o_re = clip_re ? {o_full_re[HI_W-1], {(SW-1){~o_full_re[HI_W-1]}}}
			: o_full_re[SW-1:0];
		o_im = clip_im ? {o_full_im[HI_W-1], {(SW-1){~o_full_im[HI_W-1]}}}
			: o_full_im[SW-1:0];
	end

	// configuration, coefficient tables and histories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_count_q <= ciir_pkg::COUNT_W'(1);
			den_count_q <= ciir_pkg::COUNT_W'(1);
			for (int i = 0; i < MAX_NUM_TAPS; i++) begin
				num_re_q[i] <= '0;
				num_im_q[i] <= '0;
				xh_re_q[i]  <= '0;
				xh_im_q[i]  <= '0;
			end
			for (int i = 0; i < MAX_DEN_TAPS; i++) begin
				den_re_q[i] <= '0;
				den_im_q[i] <= '0;
				yh_re_q[i]  <= '0;
				yh_im_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ciir_pkg::REG_NUM_COUNT: num_count_q <= cfg_data;
					ciir_pkg::REG_DEN_COUNT: den_count_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_xfer) begin
				unique case (op)
					ciir_pkg::OP_SAMPLE: begin
						for (int i = MAX_NUM_TAPS - 1; i > 0; i--) begin
							xh_re_q[i] <= xh_re_q[i-1];
							xh_im_q[i] <= xh_im_q[i-1];
						end
						xh_re_q[0] <= sample_re;
						xh_im_q[0] <= sample_im;
					end
					ciir_pkg::OP_LOAD_NUM: begin
						if (32'(coef_index) < MAX_NUM_TAPS) begin
							num_re_q[NUM_IW'(coef_index)] <= coef_re;
							num_im_q[NUM_IW'(coef_index)] <= coef_im;
						end
					end
					ciir_pkg::OP_LOAD_DEN: begin
						if (32'(coef_index) < MAX_DEN_TAPS) begin
							den_re_q[DEN_IW'(coef_index)] <= coef_re;
							den_im_q[DEN_IW'(coef_index)] <= coef_im;
						end
					end
					ciir_pkg::OP_CLEAR: begin
						for (int i = 0; i < MAX_NUM_TAPS; i++) begin
							xh_re_q[i] <= '0;
							xh_im_q[i] <= '0;
						end
						for (int i = 0; i < MAX_DEN_TAPS; i++) begin
							yh_re_q[i] <= '0;
							yh_im_q[i] <= '0;
						end
					end
					default: ;
				endcase
			end
			if (state_q == ST_YCALC) begin
				for (int i = MAX_DEN_TAPS - 1; i > 0; i--) begin
					yh_re_q[i] <= yh_re_q[i-1];
					yh_im_q[i] <= yh_im_q[i-1];
				end
				yh_re_q[0] <= y_new_re;
				yh_im_q[0] <= y_new_im;
			end
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			pv_q        <= 1'b0;
			pshift_q    <= 1'b0;
			psub_q      <= 1'b0;
			y_re_q      <= '0;
			y_im_q      <= '0;
			out_valid_q <= 1'b0;
			out_re_q    <= '0;
			out_im_q    <= '0;
			clipped_q   <= 1'b0;
		end else begin
			pv_q     <= issue;
			pshift_q <= (state_q == ST_DEN_LO);
			psub_q   <= (state_q != ST_NUM);
			// in emit the output register is reloaded below instead
			if (out_valid_q && out_ready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (start) begin
						state_q <= ST_NUM;
					end
				end
				ST_NUM: begin
					if (k_q == nb_last) begin
						k_q     <= '0;
						state_q <= (na_last == '0) ? ST_DRAIN : ST_DEN_HI;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DEN_HI: begin
					state_q <= ST_DEN_LO;
				end
				ST_DEN_LO: begin
					// k_q counts feedback taps from zero, coefficient index is one more
					if (k_q + 1'b1 == na_last) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_DEN_HI;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_YCALC;
				end
				ST_YCALC: begin
					y_re_q  <= y_new_re;
					y_im_q  <= y_new_im;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// wait for the output register to be free
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_re_q    <= o_re;
						out_im_q    <= o_im;
						clipped_q   <= clip_re || clip_im;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;
	assign clipped   = clipped_q;

endmodule
